// File: rtl/scbp_pkg.sv
// shared types, constants and codes for the size class buffer pool
`timescale 1ns / 1ps
`default_nettype none

package scbp_pkg;

   localparam int NUM_CLASSES_DEF = 4;
   localparam int NUM_BUFFERS_DEF = 256;
   localparam int NUM_CSR         = 4;
   localparam int HANDLE_SPACE    = 256;
   localparam int HANDLE_W        = 8;
   localparam int LEN_W           = 16;
   localparam int COUNT_W         = 9;
   localparam int STATUS_W        = 2;
   localparam int CLASS_OUT_W     = 2;
   localparam int CSR_IDX_W       = 2;
   localparam int CLASS_MAX_W     = 3;

   typedef logic [LEN_W-1:0]     len_type;
   typedef logic [HANDLE_W-1:0]  handle_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam len_type   LEN_MAX   = '1;
   localparam count_type COUNT_MAX = '1;

   localparam len_type CLASS_LEN_RESET [NUM_CSR] = '{16'd64, 16'd256, 16'd1024, 16'd4096};

   // result status codes
   localparam status_type STAT_OK         = 2'd0;
   localparam status_type STAT_LEN_UNSUP  = 2'd1;
   localparam status_type STAT_EXHAUSTED  = 2'd2;
   localparam status_type STAT_NOT_ISSUED = 2'd3;

   // request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // register indexes
   localparam csr_idx_type CSR_CLASS_LEN_0 = 2'd0;
   localparam csr_idx_type CSR_CLASS_LEN_1 = 2'd1;
   localparam csr_idx_type CSR_CLASS_LEN_2 = 2'd2;
   localparam csr_idx_type CSR_CLASS_LEN_3 = 2'd3;

   typedef struct packed {
      logic       valid;
      handle_type handle;
   } link_type;

   typedef struct packed {
      logic                   link_we;
      logic                   owner_we;
      handle_type             handle;
      link_type               link;
      logic [CLASS_MAX_W-1:0] owner;
   } mem_wr_type;

endpackage

`default_nettype wire

// File: rtl/scbp_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface scbp_req_if;
   import scbp_pkg::*;
   logic       valid;
   logic       ready;
   logic       req_type;
   len_type    req_len;
   handle_type buf_handle;

   modport source (output valid, output req_type, output req_len, output buf_handle,
                   input ready);
   modport sink   (input valid, input req_type, input req_len, input buf_handle,
                   output ready);
endinterface

interface scbp_rsp_if;
   import scbp_pkg::*;
   logic                   valid;
   logic                   ready;
   status_type             status;
   handle_type             handle_out;
   logic [CLASS_OUT_W-1:0] class_index;
   logic                   was_fresh;
   count_type              in_use_count;
   count_type              grown_count;

   modport source (output valid, output status, output handle_out, output class_index,
                   output was_fresh, output in_use_count, output grown_count,
                   input ready);
   modport sink   (input valid, input status, input handle_out, input class_index,
                   input was_fresh, input in_use_count, input grown_count,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/scbp_class_sel.sv
// first size class whose length covers the requested length
`timescale 1ns / 1ps
`default_nettype none

module scbp_class_sel #(
   parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
   parameter int CLASS_W     = 2
) (
   input  scbp_pkg::len_type                        req_len,
   input  scbp_pkg::len_type [scbp_pkg::NUM_CSR-1:0] class_len,
   output logic [CLASS_W-1:0]                       sel_class,
   output logic                                     len_unsup
);
   import scbp_pkg::*;

   always_comb begin
      len_type lim;
      logic    hit;
      lim       = LEN_MAX;
      hit       = 1'b0;
      sel_class = '0;
      // descending scan so the lowest matching class wins
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (i < NUM_CSR) begin
            lim = class_len[i[CSR_IDX_W-1:0]];
         end else begin
            lim = LEN_MAX;
         end
         if (req_len <= lim) begin
            sel_class = CLASS_W'(i);
            hit       = 1'b1;
         end
      end
      len_unsup = !hit;
   end

endmodule

`default_nettype wire

// File: rtl/scbp_list_mem.sv
// free list link memory and owner class memory, registered reads
`timescale 1ns / 1ps
`default_nettype none

module scbp_list_mem #(
   parameter int NUM_BUFFERS = scbp_pkg::NUM_BUFFERS_DEF,
   parameter int CLASS_W     = 2
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  scbp_pkg::handle_type    link_rd_handle,
   input  scbp_pkg::handle_type    owner_rd_handle,
   output scbp_pkg::link_type      link_rd_data,
   output logic [CLASS_W-1:0]      owner_rd_data,
   input  scbp_pkg::mem_wr_type    mem_wr
);
   import scbp_pkg::*;

   localparam int MEM_DEPTH = (NUM_BUFFERS < HANDLE_SPACE) ? NUM_BUFFERS : HANDLE_SPACE;
   localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   link_type           link_mem  [MEM_DEPTH];
   logic [CLASS_W-1:0] owner_mem [MEM_DEPTH];

   link_type           link_rd_ff;
   logic [CLASS_W-1:0] owner_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_wr.link_we) begin
         link_mem[mem_wr.handle[ADDR_W-1:0]] <= mem_wr.link;
      end
      if (mem_wr.owner_we) begin
         owner_mem[mem_wr.handle[ADDR_W-1:0]] <= mem_wr.owner[CLASS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         link_rd_ff  <= link_mem[link_rd_handle[ADDR_W-1:0]];
         owner_rd_ff <= owner_mem[owner_rd_handle[ADDR_W-1:0]];
      end
   end

   assign link_rd_data  = link_rd_ff;
   assign owner_rd_data = owner_rd_ff;

endmodule

`default_nettype wire

// File: rtl/size_class_buffer_pool_core.sv
// size class buffer pool: top level with list heads, counters and result register
// result: request fields and the link and owner memory read are registered at the
// request transfer, and the result register loads once no unaccepted result is held;
// a new request is taken only after the read-modify-write of list head, link and counters
// reset: synchronous, clears all free lists, the fresh counter and the per-class counts,
// and restores class lengths 64, 256, 1024, 4096; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module size_class_buffer_pool_core #(
   parameter int NUM_CLASSES = scbp_pkg::NUM_CLASSES_DEF,
   parameter int NUM_BUFFERS = scbp_pkg::NUM_BUFFERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   scbp_req_if.sink              req_chan,
   scbp_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  scbp_pkg::csr_idx_type csr_index,
   input  scbp_pkg::len_type     csr_wdata
);
   import scbp_pkg::*;

   localparam int CLASS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int MEM_DEPTH = (NUM_BUFFERS < HANDLE_SPACE) ? NUM_BUFFERS : HANDLE_SPACE;
   localparam count_type FRESH_LIMIT = COUNT_W'(MEM_DEPTH);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EXEC = 1'b1;

   logic state_ff, state_in;

   len_type [NUM_CSR-1:0] class_len_ff, class_len_in;

   logic               req_type_ff;
   handle_type         req_handle_ff;
   logic [CLASS_W-1:0] class_ff;
   logic               unsup_ff;

   logic       head_valid_ff  [NUM_CLASSES];
   logic       head_valid_in  [NUM_CLASSES];
   handle_type head_handle_ff [NUM_CLASSES];
   handle_type head_handle_in [NUM_CLASSES];
   count_type  in_use_ff      [NUM_CLASSES];
   count_type  in_use_in      [NUM_CLASSES];
   count_type  grown_ff       [NUM_CLASSES];
   count_type  grown_in       [NUM_CLASSES];
   count_type  fresh_next_ff, fresh_next_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   handle_type             rsp_handle_ff, rsp_handle_in;
   logic [CLASS_OUT_W-1:0] rsp_class_ff, rsp_class_in;
   logic                   rsp_fresh_ff, rsp_fresh_in;
   count_type              rsp_in_use_ff, rsp_in_use_in;
   count_type              rsp_grown_ff, rsp_grown_in;

   logic               sel_unsup;
   logic [CLASS_W-1:0] sel_class;
   logic               req_xfer;
   logic               exec_fire;
   link_type           link_rd;
   logic [CLASS_W-1:0] owner_rd;
   mem_wr_type         mem_wr;

   scbp_class_sel #(
      .NUM_CLASSES (NUM_CLASSES),
      .CLASS_W     (CLASS_W)
   ) u_class_sel (
      .req_len   (req_chan.req_len),
      .class_len (class_len_ff),
      .sel_class (sel_class),
      .len_unsup (sel_unsup)
   );

   scbp_list_mem #(
      .NUM_BUFFERS (NUM_BUFFERS),
      .CLASS_W     (CLASS_W)
   ) u_list_mem (
      .clock           (clock),
      .rd_en           (req_xfer),
      .link_rd_handle  (head_handle_ff[sel_class]),
      .owner_rd_handle (req_chan.buf_handle),
      .link_rd_data    (link_rd),
      .owner_rd_data   (owner_rd),
      .mem_wr          (mem_wr)
   );

   assign req_chan.ready = (state_ff == STATE_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign exec_fire      = (state_ff == STATE_EXEC) && (!rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      unique case (state_ff)
         STATE_IDLE: state_in = req_xfer ? STATE_EXEC : STATE_IDLE;
         STATE_EXEC: state_in = exec_fire ? STATE_IDLE : STATE_EXEC;
         default:    state_in = STATE_IDLE;
      endcase
   end

   always_comb begin
      class_len_in = class_len_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CLASS_LEN_0: class_len_in[0] = csr_wdata;
            CSR_CLASS_LEN_1: class_len_in[1] = csr_wdata;
            CSR_CLASS_LEN_2: class_len_in[2] = csr_wdata;
            CSR_CLASS_LEN_3: class_len_in[3] = csr_wdata;
            default:         class_len_in    = class_len_ff;
         endcase
      end
   end

   always_comb begin
      logic [CLASS_W-1:0] cls;
      count_type          iu;
      count_type          gr;
      handle_type         got;

      head_valid_in  = head_valid_ff;
      head_handle_in = head_handle_ff;
      in_use_in      = in_use_ff;
      grown_in       = grown_ff;
      fresh_next_in  = fresh_next_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_class_in   = rsp_class_ff;
      rsp_fresh_in   = rsp_fresh_ff;
      rsp_in_use_in  = rsp_in_use_ff;
      rsp_grown_in   = rsp_grown_ff;
      mem_wr         = '0;

      cls = (req_type_ff == REQ_ALLOC) ? class_ff : owner_rd;
      iu  = in_use_ff[cls];
      gr  = grown_ff[cls];
      got = head_handle_ff[cls];

      if (exec_fire) begin
         rsp_status_in = STAT_OK;
         rsp_handle_in = '0;
         rsp_class_in  = CLASS_OUT_W'(cls);
         rsp_fresh_in  = 1'b0;
         if (req_type_ff == REQ_ALLOC) begin
            if (unsup_ff) begin
               rsp_status_in = STAT_LEN_UNSUP;
               rsp_class_in  = '0;
               iu            = '0;
               gr            = '0;
            end else if (head_valid_ff[cls]) begin
               // pop from the class free list
               head_handle_in[cls] = link_rd.handle;
               head_valid_in[cls]  = link_rd.valid;
               if (iu != COUNT_MAX) iu = iu + 1'b1;
               rsp_handle_in = got;
            end else if (fresh_next_ff < FRESH_LIMIT) begin
               // issue a never-used handle
               got             = fresh_next_ff[HANDLE_W-1:0];
               fresh_next_in   = fresh_next_ff + 1'b1;
               mem_wr.owner_we = 1'b1;
               mem_wr.handle   = got;
               mem_wr.owner    = CLASS_MAX_W'(cls);
               if (gr != COUNT_MAX) gr = gr + 1'b1;
               if (iu != COUNT_MAX) iu = iu + 1'b1;
               rsp_handle_in = got;
               rsp_fresh_in  = 1'b1;
            end else begin
               rsp_status_in = STAT_EXHAUSTED;
            end
         end else begin
            rsp_handle_in = req_handle_ff;
            if ({1'b0, req_handle_ff} >= fresh_next_ff) begin
               rsp_status_in = STAT_NOT_ISSUED;
               rsp_class_in  = '0;
               iu            = '0;
               gr            = '0;
            end else begin
               // push onto the owner class free list
               mem_wr.link_we      = 1'b1;
               mem_wr.handle       = req_handle_ff;
               mem_wr.link.valid   = head_valid_ff[cls];
               mem_wr.link.handle  = head_handle_ff[cls];
               head_handle_in[cls] = req_handle_ff;
               head_valid_in[cls]  = 1'b1;
               if (iu != '0) iu = iu - 1'b1;
            end
         end
         if (rsp_status_in == STAT_OK) begin
            in_use_in[cls] = iu;
            grown_in[cls]  = gr;
         end
         rsp_in_use_in = iu;
         rsp_grown_in  = gr;
      end
   end

   always_comb begin
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         rsp_valid_ff  <= 1'b0;
         fresh_next_ff <= '0;
         for (int i = 0; i < NUM_CSR; i++) begin
            class_len_ff[i] <= CLASS_LEN_RESET[i];
         end
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_valid_ff[i] <= 1'b0;
            in_use_ff[i]     <= '0;
            grown_ff[i]      <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         fresh_next_ff <= fresh_next_in;
         class_len_ff  <= class_len_in;
         head_valid_ff <= head_valid_in;
         in_use_ff     <= in_use_in;
         grown_ff      <= grown_in;
      end
   end

   always_ff @(posedge clock) begin
      head_handle_ff <= head_handle_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_class_ff   <= rsp_class_in;
      rsp_fresh_ff   <= rsp_fresh_in;
      rsp_in_use_ff  <= rsp_in_use_in;
      rsp_grown_ff   <= rsp_grown_in;
      if (req_xfer) begin
         req_type_ff   <= req_chan.req_type;
         req_handle_ff <= req_chan.buf_handle;
         class_ff      <= sel_class;
         unsup_ff      <= sel_unsup;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.handle_out   = rsp_handle_ff;
   assign rsp_chan.class_index  = rsp_class_ff;
   assign rsp_chan.was_fresh    = rsp_fresh_ff;
   assign rsp_chan.in_use_count = rsp_in_use_ff;
   assign rsp_chan.grown_count  = rsp_grown_ff;

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for the size class buffer pool: predicting scoreboard, directed and random traffic
`timescale 1ns / 1ps

module testbench;
   import scbp_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int FRESH_LIMIT    = (NUM_BUFFERS_DEF < HANDLE_SPACE) ? NUM_BUFFERS_DEF : HANDLE_SPACE;
   localparam csr_idx_type CSR_IDS [NUM_CSR] =
      '{CSR_CLASS_LEN_0, CSR_CLASS_LEN_1, CSR_CLASS_LEN_2, CSR_CLASS_LEN_3};

   typedef struct packed {
      logic       kind;
      len_type    len;
      handle_type handle;
   } pool_req_type;

   typedef struct packed {
      status_type             status;
      handle_type             handle;
      logic [CLASS_OUT_W-1:0] cls;
      logic                   fresh;
      count_type              in_use;
      count_type              grown;
   } pool_rsp_type;

   class pool_scoreboard;
      len_type      lens [NUM_CSR];
      handle_type   link_next [HANDLE_SPACE];
      bit           link_ok [HANDLE_SPACE];
      logic [1:0]   owner [HANDLE_SPACE];
      handle_type   head [NUM_CLASSES_DEF];
      bit           head_ok [NUM_CLASSES_DEF];
      int           fresh_next;
      count_type    used_cnt [NUM_CLASSES_DEF];
      count_type    grown_cnt [NUM_CLASSES_DEF];
      pool_rsp_type expected_q [$];
      handle_type   outstanding [$];
      int           errors;

      function new();
         lens       = CLASS_LEN_RESET;
         fresh_next = 0;
         errors     = 0;
         for (int i = 0; i < NUM_CLASSES_DEF; i++) begin
            head_ok[i]   = 1'b0;
            head[i]      = '0;
            used_cnt[i]  = '0;
            grown_cnt[i] = '0;
         end
      endfunction

      function void note_request(pool_req_type r);
         pool_rsp_type e;
         int           c;
         handle_type   got;
         e = '0;
         if (r.kind == REQ_ALLOC) begin
            c = NUM_CLASSES_DEF;
            for (int i = NUM_CLASSES_DEF - 1; i >= 0; i--)
               if (r.len <= lens[i]) c = i;
            if (c == NUM_CLASSES_DEF) begin
               e.status = STAT_LEN_UNSUP;
            end else if (head_ok[c] || fresh_next < FRESH_LIMIT) begin
               if (head_ok[c]) begin
                  got        = head[c];
                  head[c]    = link_next[got];
                  head_ok[c] = link_ok[got];
                  e.fresh    = 1'b0;
               end else begin
                  got        = handle_type'(fresh_next);
                  fresh_next = fresh_next + 1;
                  owner[got] = c[1:0];
                  if (grown_cnt[c] < COUNT_MAX) grown_cnt[c]++;
                  e.fresh = 1'b1;
               end
               if (used_cnt[c] < COUNT_MAX) used_cnt[c]++;
               e.status = STAT_OK;
               e.handle = got;
               e.cls    = c[1:0];
               e.in_use = used_cnt[c];
               e.grown  = grown_cnt[c];
               outstanding.push_back(got);
            end else begin
               e.status = STAT_EXHAUSTED;
               e.cls    = c[1:0];
               e.in_use = used_cnt[c];
               e.grown  = grown_cnt[c];
            end
         end else if (r.handle >= fresh_next) begin
            e.status = STAT_NOT_ISSUED;
            e.handle = r.handle;
         end else begin
            c                   = owner[r.handle];
            link_next[r.handle] = head[c];
            link_ok[r.handle]   = head_ok[c];
            head[c]             = r.handle;
            head_ok[c]          = 1'b1;
            if (used_cnt[c] > 0) used_cnt[c]--;
            e.status = STAT_OK;
            e.handle = r.handle;
            e.cls    = c[1:0];
            e.in_use = used_cnt[c];
            e.grown  = grown_cnt[c];
            for (int i = 0; i < outstanding.size(); i++)
               if (outstanding[i] == r.handle) begin
                  outstanding.delete(i);
                  break;
               end
         end
         expected_q.push_back(e);
      endfunction

      function void check_result(pool_rsp_type got);
         pool_rsp_type e;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: status %0d handle %0d class %0d", got.status,
                        got.handle, got.cls);
            return;
         end
         e = expected_q.pop_front();
         if (got.status !== e.status || got.handle !== e.handle || got.cls !== e.cls ||
             got.fresh !== e.fresh || got.in_use !== e.in_use || got.grown !== e.grown) begin
            errors++;
            if (errors <= 10)
               $display({"result mismatch: expected status %0d handle %0d class %0d fresh %0d ",
                         "in_use %0d grown %0d, got status %0d handle %0d class %0d fresh %0d ",
                         "in_use %0d grown %0d"},
                        e.status, e.handle, e.cls, e.fresh, e.in_use, e.grown,
                        got.status, got.handle, got.cls, got.fresh, got.in_use, got.grown);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   csr_idx_type csr_index;
   len_type     csr_wdata;

   scbp_req_if req_bus ();
   scbp_rsp_if rsp_bus ();

   size_class_buffer_pool_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pool_scoreboard sb;
   bit             steady_flow = 1'b0;
   bit             hold_start  = 1'b0;
   int             hold_left   = 0;
   int             quiet_cycles = 0;

   always #5 clock = ~clock;

   // result side: random back-pressure and one long hold-off
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_CYCLES;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (steady_flow) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= 11);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      pool_rsp_type seen;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         seen.status = rsp_bus.status;
         seen.handle = rsp_bus.handle_out;
         seen.cls    = rsp_bus.class_index;
         seen.fresh  = rsp_bus.was_fresh;
         seen.in_use = rsp_bus.in_use_count;
         seen.grown  = rsp_bus.grown_count;
         sb.check_result(seen);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
          (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic pool_req_type alloc_req(input len_type len);
      pool_req_type r;
      r = '0;
      r.kind   = REQ_ALLOC;
      r.len    = len;
      r.handle = handle_type'($urandom);
      return r;
   endfunction

   function automatic pool_req_type free_req(input handle_type h);
      pool_req_type r;
      r = '0;
      r.kind   = REQ_FREE;
      r.len    = len_type'($urandom);
      r.handle = h;
      return r;
   endfunction

   function automatic len_type pick_len();
      int pick;
      pick = $urandom_range(9);
      if (pick < 4) return len_type'(sb.lens[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1);
      if (pick == 4) return '0;
      if (pick == 5) return LEN_MAX;
      if (pick < 8) return len_type'($urandom_range(0, sb.lens[3]));
      return len_type'($urandom);
   endfunction

   function automatic pool_req_type next_pool_request(input int alloc_pct);
      int pick;
      pick = $urandom_range(99);
      if (pick < alloc_pct)
         return alloc_req(pick_len());
      if (pick < 96 && sb.outstanding.size() > 0)
         return free_req(sb.outstanding[$urandom_range(0, sb.outstanding.size() - 1)]);
      if ($urandom_range(1))
         return free_req(handle_type'($urandom_range(0, 255)));
      return free_req(handle_type'(sb.fresh_next + $urandom_range(0, 2) - 1));
   endfunction

   task automatic send_request(input pool_req_type r);
      if (!steady_flow && $urandom_range(99) < 11) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= r.kind;
      req_bus.req_len    <= r.len;
      req_bus.buf_handle <= r.handle;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(r);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_class_lens(input len_type l0, l1, l2, l3);
      len_type v [NUM_CSR];
      v = '{l0, l1, l2, l3};
      for (int i = 0; i < NUM_CSR; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDS[i];
         csr_wdata <= v[i];
         @(posedge clock);
         sb.lens[i] = v[i];
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_random(input int count, input int alloc_pct);
      for (int i = 0; i < count; i++) send_request(next_pool_request(alloc_pct));
      drain();
   endtask

   initial begin
      int a, b, c;
      sb = new();
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_CLASS_LEN_0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_ALLOC;
      req_bus.req_len    = '0;
      req_bus.buf_handle = '0;
      rsp_bus.ready      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // directed: class boundaries under reset lengths, lifo reuse, unissued frees
      send_request(alloc_req(16'd0));
      send_request(alloc_req(16'd64));
      send_request(alloc_req(16'd65));
      send_request(alloc_req(16'd256));
      send_request(alloc_req(16'd257));
      send_request(alloc_req(16'd1024));
      send_request(alloc_req(16'd1025));
      send_request(alloc_req(16'd4096));
      send_request(alloc_req(16'd4097));
      send_request(alloc_req(LEN_MAX));
      send_request(free_req(8'd255));
      send_request(free_req(8'd0));
      send_request(free_req(8'd1));
      send_request(alloc_req(16'd10));
      send_request(alloc_req(16'd10));
      send_request(alloc_req(16'd10));
      send_request(free_req(8'd3));
      send_request(alloc_req(16'd200));
      send_request(free_req(handle_type'(sb.fresh_next)));
      send_request(free_req(handle_type'(sb.fresh_next - 1)));
      drain();

      // allocation heavy, runs the fresh handles out
      run_random(500, 85);

      set_class_lens(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
      run_random(150, 55);

      set_class_lens('0, '0, '0, '0);
      run_random(100, 55);

      // ascending random lengths, with a long hold-off on the result side
      a = $urandom_range(0, 300);
      b = a + $urandom_range(1, 3000);
      c = b + $urandom_range(1, 10000);
      set_class_lens(len_type'(a), len_type'(b), len_type'(c),
                     len_type'(c + $urandom_range(1, 65535 - c)));
      hold_start = 1'b1;
      run_random(200, 55);

      // unordered lengths, no idling on either side
      set_class_lens(len_type'($urandom), len_type'($urandom), len_type'($urandom),
                     len_type'($urandom));
      steady_flow = 1'b1;
      run_random(200, 55);
      steady_flow = 1'b0;

      set_class_lens(16'd64, 16'd256, 16'd1024, 16'd4096);
      run_random(150, 55);

      // double free makes a self loop, repeated allocation saturates the in-use count
      c = sb.owner[0];
      send_request(free_req(8'd0));
      send_request(free_req(8'd0));
      for (int i = 0; i < 520; i++) send_request(alloc_req(sb.lens[c]));
      for (int i = 0; i < 4; i++) send_request(free_req(8'd0));
      drain();
      repeat (8) @(posedge clock);

      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: sim.f
rtl/scbp_pkg.sv
rtl/scbp_ifs.sv
rtl/scbp_class_sel.sv
rtl/scbp_list_mem.sv
rtl/size_class_buffer_pool_core.sv
dv/testbench.sv
